### design/pest_pkg.sv
// ----------------------------------------------------------------------------
// Polygon edge span tracer package
// Command codes, table constants and the control and status bundles shared
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pest_pkg;

  // Command codes carried in the input tuser field.
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_TRACE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // Row minimum seen in a row that has never been written since reset.
  localparam logic [7:0] RESET_MIN = 8'd80;

  // Width of the error term; err + dx stays below 2^9 for 5-bit y and 8-bit x.
  localparam int ERR_W = 9;

  // Operations requested of the datapath for the current cycle.
  typedef struct packed {
    logic load;        // latch a new request and set up the edge walk
    logic clr_wr;      // write the empty span to the current row
    logic add;         // start a row: remember x, add dx to the error term
    logic step;        // one x step, subtract dy from the error term
    logic rd;          // read the current row from the table
    logic widen;       // write back the widened span of the current row
    logic y_inc;       // move to the next row
    logic set_final;   // the next row is the bottom row of the edge
    logic out_load;    // place the result in the output register
  } dp_cmd_t;

  // Status reported by the datapath to the controller.
  typedef struct packed {
    logic [1:0] cmd;        // command of the request in progress
    logic       y_eq;       // current row equals the last row
    logic       y_gt;       // current row lies after the last row
    logic       next_last;  // the row after the current one is the last row
    logic       err_ge;     // error term has reached dy
    logic       steep;      // edge has dx not greater than dy
    logic       final_row;  // the bottom row is being processed
    logic       out_free;   // output register can take a result
  } dp_stat_t;

endpackage

`default_nettype wire

### design/pest_dp.sv
// ----------------------------------------------------------------------------
// Polygon edge span tracer datapath
// Holds the edge walk registers, the row span table with its valid bits and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pest_dp #(
  parameter int ROWS = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire pest_pkg::dp_cmd_t cmd_i,
  output pest_pkg::dp_stat_t   stat_o,
  input  wire  [31:0]          in_tdata_i,
  input  wire  [1:0]           in_tuser_i,
  input  wire  [7:0]           empty_min_i,
  output logic                 out_tvalid_o,
  input  wire                  out_tready_i,
  output logic [23:0]          out_tdata_o,
  output logic [1:0]           out_tuser_o
);

  localparam int RowAw = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ExtW  = (RowAw > 5) ? RowAw : 5;

  // Request fields from the input tdata.
  logic [7:0] fx, sx, x1, x2, dx_n;
  logic [4:0] fy, sy, ya, yb, dy_n;
  logic       swap, right_n;

  assign fx = in_tdata_i[7:0];
  assign fy = in_tdata_i[12:8];
  assign sx = in_tdata_i[20:13];
  assign sy = in_tdata_i[25:21];

  // An edge is walked top to bottom; clear and read keep their row order.
  assign swap    = (in_tuser_i == pest_pkg::CMD_TRACE) && (fy > sy);
  assign x1      = swap ? sx : fx;
  assign x2      = swap ? fx : sx;
  assign ya      = swap ? sy : fy;
  assign yb      = swap ? fy : sy;
  assign dy_n    = yb - ya;
  assign right_n = x2 > x1;
  assign dx_n    = right_n ? (x2 - x1) : (x1 - x2);

  // Walk registers.
  logic [1:0]                   cmd_q;
  logic [4:0]                   y_q, y2_q, dy_q;
  logic [7:0]                   x_q, start_x_q, dx_q;
  logic [pest_pkg::ERR_W-1:0]   err_q;
  logic                         right_q, steep_q, final_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= in_tuser_i;
      y_q     <= ya;
      y2_q    <= yb;
      x_q     <= x1;
      dy_q    <= dy_n;
      dx_q    <= dx_n;
      right_q <= right_n;
      steep_q <= ({3'b000, dy_n} >= dx_n);
      err_q   <= pest_pkg::ERR_W'(dy_n >> 1);
    end else if (cmd_i.add) begin
      start_x_q <= x_q;
      err_q     <= err_q + pest_pkg::ERR_W'(dx_q);
    end else if (cmd_i.step) begin
      x_q   <= right_q ? (x_q + 8'd1) : (x_q - 8'd1);
      err_q <= err_q - pest_pkg::ERR_W'(dy_q);
    end else if (cmd_i.y_inc) begin
      y_q <= y_q + 5'd1;
    end
  end

  // Bottom row flag of the edge walk.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      final_q <= 1'b0;
    end else if (cmd_i.load) begin
      final_q <= 1'b0;
    end else if (cmd_i.set_final) begin
      final_q <= 1'b1;
    end
  end

  // Row address; rows at or beyond the table depth are never written.
  logic [ExtW-1:0]  y_ext;
  logic [RowAw-1:0] addr;
  logic             row_ok;

  assign y_ext  = ExtW'(y_q);
  assign addr   = y_ext[RowAw-1:0];
  assign row_ok = int'(y_q) < ROWS;

  // Span table with a valid bit per row; an unwritten row reads as empty.
  logic [7:0]      min_mem [ROWS];
  logic [7:0]      max_mem [ROWS];
  logic [ROWS-1:0] valid_q;
  logic [7:0]      rd_min_q, rd_max_q, cur_min, cur_max;
  logic            rd_vld_q;
  logic [7:0]      cand_min, cand_max, new_min, new_max, wr_min, wr_max;
  logic            wr_en;

  assign cur_min = rd_vld_q ? rd_min_q : pest_pkg::RESET_MIN;
  assign cur_max = rd_vld_q ? rd_max_q : 8'd0;

  // Candidate span of the row: the final x on the bottom row, one x on a
  // steep edge, and the whole run of steps on a shallow edge.
  always_comb begin
    if (final_q) begin
      cand_min = x_q;
      cand_max = x_q;
    end else if (steep_q) begin
      cand_min = start_x_q;
      cand_max = start_x_q;
    end else if (right_q) begin
      cand_min = start_x_q;
      cand_max = x_q;
    end else begin
      cand_min = x_q;
      cand_max = start_x_q;
    end
  end

  assign new_min = (cand_min < cur_min) ? cand_min : cur_min;
  assign new_max = (cand_max > cur_max) ? cand_max : cur_max;
  assign wr_en   = (cmd_i.clr_wr || cmd_i.widen) && row_ok;
  assign wr_min  = cmd_i.clr_wr ? empty_min_i : new_min;
  assign wr_max  = cmd_i.clr_wr ? 8'd0 : new_max;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      min_mem[addr] <= wr_min;
      max_mem[addr] <= wr_max;
    end
    if (cmd_i.rd) begin
      rd_min_q <= min_mem[addr];
      rd_max_q <= max_mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[addr] <= 1'b1;
      end
      if (cmd_i.rd) begin
        rd_vld_q <= valid_q[addr];
      end
    end
  end

  // Result of the request; only a read of an existing row carries a span.
  logic       is_read;
  logic [7:0] res_min, res_max;
  logic       res_valid;

  assign is_read   = (cmd_q == pest_pkg::CMD_READ) && row_ok;
  assign res_min   = is_read ? cur_min : 8'd0;
  assign res_max   = is_read ? cur_max : 8'd0;
  assign res_valid = is_read && (cur_max >= cur_min);

  // Output register, which frees the input side while a result waits.
  logic        out_valid_q;
  logic [23:0] out_data_q;
  logic [1:0]  out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {7'b0000000, res_valid, res_max, res_min};
      out_user_q <= cmd_q;
    end
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = out_data_q;
  assign out_tuser_o  = out_user_q;

  // Status towards the controller.
  assign stat_o.cmd       = cmd_q;
  assign stat_o.y_eq      = (y_q == y2_q);
  assign stat_o.y_gt      = (y_q > y2_q);
  assign stat_o.next_last = ((y_q + 5'd1) == y2_q);
  assign stat_o.err_ge    = (err_q >= pest_pkg::ERR_W'(dy_q));
  assign stat_o.steep     = steep_q;
  assign stat_o.final_row = final_q;
  assign stat_o.out_free  = !out_valid_q || out_tready_i;

endmodule

`default_nettype wire

### design/pest_ctrl.sv
// ----------------------------------------------------------------------------
// Polygon edge span tracer controller
// Sequences clear, trace and read requests over the datapath, one request at
// a time.
// ----------------------------------------------------------------------------
`default_nettype none

module pest_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_tvalid_i,
  output logic                 in_tready_o,
  output pest_pkg::dp_cmd_t    cmd_o,
  input  wire pest_pkg::dp_stat_t stat_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_CLR   = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_STEP  = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_WR    = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_tready_o = (state_q == S_IDLE);

  // Next state and datapath operations.
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        unique case (stat_i.cmd)
          pest_pkg::CMD_CLEAR: state_d = stat_i.y_gt ? S_DONE : S_CLR;
          pest_pkg::CMD_TRACE: state_d = stat_i.y_eq ? S_DONE : S_ADD;
          pest_pkg::CMD_READ:  state_d = S_RD;
          default:             state_d = S_DONE;
        endcase
      end
      S_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.y_eq) begin
          state_d = S_DONE;
        end else begin
          cmd_o.y_inc = 1'b1;
        end
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_STEP;
      end
      S_STEP: begin
        // A steep edge takes at most one step per row.
        cmd_o.step = stat_i.err_ge;
        if (stat_i.steep || !stat_i.err_ge) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = (stat_i.cmd == pest_pkg::CMD_READ) ? S_DONE : S_WR;
      end
      S_WR: begin
        cmd_o.widen = 1'b1;
        if (stat_i.final_row) begin
          state_d = S_DONE;
        end else begin
          cmd_o.y_inc = 1'b1;
          if (stat_i.next_last) begin
            cmd_o.set_final = 1'b1;
            state_d         = S_RD;
          end else begin
            state_d = S_ADD;
          end
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### design/polygon_edge_span_tracer_top.sv
// Throughput: one request at a time.
// Reset: the table reads empty (minimum 80, maximum 0) at once through per-row
// valid bits; empty_min returns to 80.
// ----------------------------------------------------------------------------
// Polygon edge span tracer
// Per-row span table filled by Bresenham edge tracing, with an APB register
// for the cleared minimum value.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_edge_span_tracer_top #(
  parameter int ROWS = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Input requests.
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,  // first_x[7:0], first_y[12:8], second_x[20:13],
                                     // second_y[25:21], zero[31:26]
  input  wire  [1:0]  s_axis_tuser,  // command[1:0]
  // Results.
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,  // span_min[7:0], span_max[15:8], span_valid[16],
                                     // zero[23:17]
  output logic [1:0]  m_axis_tuser,  // done_command[1:0]
  // Configuration.
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_EMPTY_MIN = 1'b0;

  // Configuration register.
  logic [7:0] empty_min_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_EMPTY_MIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_min_q <= pest_pkg::RESET_MIN;
    end else if (cfg_wr) begin
      empty_min_q <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_EMPTY_MIN) ? {24'd0, empty_min_q} : 32'd0;

  // Controller and datapath.
  pest_pkg::dp_cmd_t  dp_cmd;
  pest_pkg::dp_stat_t dp_stat;

  pest_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_tready_o (s_axis_tready),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  pest_dp #(
    .ROWS (ROWS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .empty_min_i  (empty_min_q),
    .out_tvalid_o (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .out_tdata_o  (m_axis_tdata),
    .out_tuser_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

### verif/tb_polygon_edge_span_tracer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Polygon edge span tracer testbench
// Drives clear, trace, read and no-op requests into the span tracer and
// checks every result against a span table of its own. The table is walked
// with the same Bresenham stepping as the block. Both stream sides idle at
// random, and the result side holds off once for a long stretch. The cleared
// minimum register is changed between phases, with both extremes included.
// ----------------------------------------------------------------------------

module tb_polygon_edge_span_tracer_top;

  localparam int          NUM_ROWS       = 32;
  localparam logic [2:0]  EMPTY_MIN_ADDR = 3'd0;
  localparam int          PHASE_REQS     = 400;
  localparam int          HOLD_AT        = 300;
  localparam int          HOLD_CYCLES    = 600;
  localparam int          TAIL_CYCLES    = 600;

  // One input request and one result, field by field.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] x_a;
    logic [4:0] y_a;
    logic [7:0] x_b;
    logic [4:0] y_b;
  } span_req_t;

  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
    logic       nonempty;
    logic [1:0] op;
  } span_res_t;

  // Span table predictor and the queue of results it expects.
  class span_scoreboard;
    logic [7:0] row_lo[NUM_ROWS];
    logic [7:0] row_hi[NUM_ROWS];
    logic [7:0] clear_min;
    span_res_t  expected_q[$];
    int mismatches;
    int checked;
    int n_clear, n_trace, n_read, n_nop, n_filled;

    function new();
      clear_min = pest_pkg::RESET_MIN;
      for (int i = 0; i < NUM_ROWS; i++) begin
        row_lo[i] = pest_pkg::RESET_MIN;
        row_hi[i] = 8'd0;
      end
    endfunction

    function void set_clear_min(logic [7:0] v);
      clear_min = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void widen(int y, int x_lo, int x_hi);
      if (y < NUM_ROWS) begin
        if (x_lo < row_lo[y]) row_lo[y] = x_lo[7:0];
        if (x_hi > row_hi[y]) row_hi[y] = x_hi[7:0];
      end
    endfunction

    // Walk one edge from its top row down, widening each row it crosses.
    function void walk_edge(int xa, int ya, int xb, int yb);
      int x1, y1, x2, y2, dx, dy, err, x, y, run_start;
      bit right;
      if (ya == yb) return;
      if (ya < yb) begin
        x1 = xa; y1 = ya; x2 = xb; y2 = yb;
      end else begin
        x1 = xb; y1 = yb; x2 = xa; y2 = ya;
      end
      dy = y2 - y1;
      err = dy >> 1;
      right = (x2 > x1);
      dx = right ? x2 - x1 : x1 - x2;
      x = x1;
      if (dx > dy) begin
        // Shallow edge: a row covers the whole run of x steps taken on it.
        for (y = y1; y < y2; y++) begin
          run_start = x;
          err += dx;
          while (err >= dy) begin
            x = right ? ((x + 1) & 8'hFF) : ((x - 1) & 8'hFF);
            err -= dy;
          end
          if (right) widen(y, run_start, x);
          else widen(y, x, run_start);
        end
      end else begin
        // Steep edge: one x per row, at most one step between rows.
        for (y = y1; y < y2; y++) begin
          widen(y, x, x);
          err += dx;
          if (err >= dy) begin
            x = right ? ((x + 1) & 8'hFF) : ((x - 1) & 8'hFF);
            err -= dy;
          end
        end
      end
      widen(y2, x, x);
    endfunction

    function void note_request(span_req_t r);
      span_res_t res;
      res = '0;
      res.op = r.op;
      case (r.op)
        pest_pkg::CMD_CLEAR: begin
          n_clear++;
          for (int i = r.y_a; i <= r.y_b; i++) begin
            if (i < NUM_ROWS) begin
              row_lo[i] = clear_min;
              row_hi[i] = 8'd0;
            end
          end
        end
        pest_pkg::CMD_TRACE: begin
          n_trace++;
          walk_edge(r.x_a, r.y_a, r.x_b, r.y_b);
        end
        pest_pkg::CMD_READ: begin
          n_read++;
          if (r.y_a < NUM_ROWS) begin
            res.lo = row_lo[r.y_a];
            res.hi = row_hi[r.y_a];
            res.nonempty = (row_hi[r.y_a] >= row_lo[r.y_a]);
            if (res.nonempty) n_filled++;
          end
        end
        default: n_nop++;
      endcase
      expected_q.push_back(res);
    endfunction

    function void check_result(span_res_t got);
      span_res_t want;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result with no request pending: min=%0d max=%0d valid=%0d cmd=%0d",
                   $time, got.lo, got.hi, got.nonempty, got.op);
        return;
      end
      want = expected_q.pop_front();
      if (got.lo !== want.lo || got.hi !== want.hi || got.nonempty !== want.nonempty ||
          got.op !== want.op) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"[%0t] result %0d: expected min=%0d max=%0d valid=%0d cmd=%0d,",
                    " got min=%0d max=%0d valid=%0d cmd=%0d"},
                   $time, checked, want.lo, want.hi, want.nonempty, want.op,
                   got.lo, got.hi, got.nonempty, got.op);
      end
    endfunction
  endclass

  // Clock, reset and block ports.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_ready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [23:0] m_axis_tdata;
  wire  [1:0]  m_axis_tuser;
  wire  [31:0] prdata;
  wire         pready;

  span_scoreboard sb = new();
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int sent_count = 0;
  int settings_used = 1;

  polygon_edge_span_tracer_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Overall limit on the run.
  initial begin
    #100_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic span_req_t make_req(logic [1:0] op, int xa, int ya, int xb, int yb);
    span_req_t r;
    r.op  = op;
    r.x_a = xa[7:0];
    r.y_a = ya[4:0];
    r.x_b = xb[7:0];
    r.y_b = yb[4:0];
    return r;
  endfunction

  // Offer one request after a random gap and wait until it is taken.
  task automatic send_request(span_req_t r);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, r.y_b, r.x_b, r.y_a, r.x_a};
    s_tuser  <= r.op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(r);
    sent_count++;
    if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
  endtask

  // Let every outstanding result drain before touching the register.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_clear_min(logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= EMPTY_MIN_ADDR;
    pwdata  <= {24'b0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_clear_min(v);
  endtask

  // A closed polygon within a band of rows: usually a clear, then its edges traced, then read back.
  task automatic polygon_burst();
    int top, bot, n;
    int vx[8];
    int vy[8];
    top = $urandom_range(0, 31);
    bot = ($urandom_range(0, 3) == 0) ? 31 :
          $urandom_range(top, (top + 12 > 31) ? 31 : top + 12);
    n = $urandom_range(3, 6);
    if ($urandom_range(0, 3) != 0)
      send_request(make_req(pest_pkg::CMD_CLEAR, $urandom_range(0, 255), top,
                            $urandom_range(0, 255), bot));
    for (int k = 0; k < n; k++) begin
      vx[k] = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 255);
      vy[k] = $urandom_range(top, bot);
    end
    for (int k = 0; k < n; k++)
      send_request(make_req(pest_pkg::CMD_TRACE, vx[k], vy[k], vx[(k + 1) % n],
                            vy[(k + 1) % n]));
    for (int y = top; y <= bot; y++)
      send_request(make_req(pest_pkg::CMD_READ, $urandom_range(0, 255), y,
                            $urandom_range(0, 255), $urandom_range(0, 31)));
  endtask

  // Result side: random stalls, one long hold-off, every result checked.
  initial begin
    int stall;
    int taken;
    span_res_t got;
    taken = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 15);
      if (taken == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.lo       = m_axis_tdata[7:0];
      got.hi       = m_axis_tdata[15:8];
      got.nonempty = m_axis_tdata[16];
      got.op       = m_axis_tuser;
      sb.check_result(got);
      taken++;
      if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
    end
  end

  // Main sequence.
  initial begin
    logic [7:0] settings[5];
    int phase_start;
    settings[0] = 8'd0;
    settings[1] = 8'd255;
    settings[2] = 8'($urandom_range(1, 254));
    settings[3] = 8'($urandom_range(0, 255));
    settings[4] = pest_pkg::RESET_MIN;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset value of the cleared minimum.
    send_request(make_req(pest_pkg::CMD_READ, 0, 0, 0, 0));
    send_request(make_req(pest_pkg::CMD_NOP, 255, 31, 255, 31));
    // Horizontal edge leaves the table alone.
    send_request(make_req(pest_pkg::CMD_TRACE, 10, 5, 200, 5));
    send_request(make_req(pest_pkg::CMD_READ, 0, 5, 0, 0));
    // Shallow edges in both directions, given bottom first in the second case.
    send_request(make_req(pest_pkg::CMD_TRACE, 0, 0, 255, 3));
    send_request(make_req(pest_pkg::CMD_READ, 0, 1, 0, 0));
    send_request(make_req(pest_pkg::CMD_READ, 0, 3, 0, 0));
    send_request(make_req(pest_pkg::CMD_TRACE, 0, 10, 255, 8));
    send_request(make_req(pest_pkg::CMD_READ, 0, 9, 0, 0));
    // Steep edge, a vertical edge over the full height and a diagonal.
    send_request(make_req(pest_pkg::CMD_TRACE, 100, 12, 103, 31));
    send_request(make_req(pest_pkg::CMD_READ, 0, 31, 0, 0));
    send_request(make_req(pest_pkg::CMD_TRACE, 50, 31, 50, 0));
    send_request(make_req(pest_pkg::CMD_TRACE, 0, 0, 31, 31));
    send_request(make_req(pest_pkg::CMD_READ, 0, 20, 0, 0));
    send_request(make_req(pest_pkg::CMD_READ, 0, 0, 0, 0));
    // Clear with its first row after its last row clears nothing.
    send_request(make_req(pest_pkg::CMD_CLEAR, 0, 20, 0, 4));
    send_request(make_req(pest_pkg::CMD_READ, 0, 5, 0, 0));
    // Single-row clear, then the whole table.
    send_request(make_req(pest_pkg::CMD_CLEAR, 0, 31, 0, 31));
    send_request(make_req(pest_pkg::CMD_READ, 0, 31, 0, 0));
    send_request(make_req(pest_pkg::CMD_CLEAR, 255, 0, 255, 31));
    send_request(make_req(pest_pkg::CMD_READ, 0, 0, 0, 0));
    send_request(make_req(pest_pkg::CMD_NOP, 0, 0, 0, 0));

    // Random phases, each under its own cleared minimum.
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      write_clear_min(settings[p]);
      settings_used++;
      phase_start = sent_count;
      while (sent_count - phase_start < PHASE_REQS) begin
        if ($urandom_range(0, 9) < 7) begin
          polygon_burst();
        end else begin
          send_request(make_req(2'($urandom_range(0, 3)), $urandom_range(0, 255),
                                $urandom_range(0, 31), $urandom_range(0, 255),
                                $urandom_range(0, 31)));
        end
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display({"Sent %0d requests (%0d traces, %0d reads, %0d clears, %0d no-ops)",
              " under %0d settings of the cleared minimum."},
             sent_count, sb.n_trace, sb.n_read, sb.n_clear, sb.n_nop, settings_used);
    $display("Checked %0d results; %0d reads found a non-empty span.", sb.checked, sb.n_filled);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
